>>> rtl/cubic_bezier_tessellator_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cubic Bezier tessellator
// Clock clk_i and reset rst_ni are taken from the including scope.
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_TESSELLATOR_CORE_ASSERT_SVH
`define CUBIC_BEZIER_TESSELLATOR_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define CBT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbt assertion failed");

// Consequent holds in the cycle after the antecedent.
`define CBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbt assertion failed");

`endif

>>> rtl/cbt_pkg.sv
// ---------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants of the cubic Bezier tessellator.
// ---------------------------------------------------------------------------
package cbt_pkg;

  localparam int MaxResolution  = 63;
  localparam int WeightFracBits = 16;
  localparam int PointW         = 16;
  localparam int CoordW         = 24;
  localparam int ResW           = 6;
  localparam int PdataW         = 32;
  localparam int PaddrW         = 2;
  localparam int SegQueueDepth  = 2;

  localparam logic [ResW-1:0]   ResolutionReset = 6'd16;
  localparam logic [PaddrW-1:0] RegResolution   = 2'd0;

  typedef struct packed {
    logic                     start_new;
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] curve_x;
    logic signed [CoordW-1:0] curve_y;
    logic                     last_of_segment;
  } out_item_t;

  typedef struct packed {
    logic signed [PointW-1:0] x;
    logic signed [PointW-1:0] y;
  } point_t;

  typedef struct packed {
    point_t p3;
    point_t p2;
    point_t p1;
    point_t p0;
  } seg_t;

endpackage

>>> rtl/cbt_ram.sv
// ---------------------------------------------------------------------------
// cbt_ram
// Generic RAM: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module cbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> rtl/cbt_front.sv
// ---------------------------------------------------------------------------
// cbt_front
// Accepts control points, holds start and inner points, emits full segments.
// ---------------------------------------------------------------------------
module cbt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  cbt_pkg::in_item_t in_item_i,
  output logic              in_ready_o,
  input  logic              tbl_busy_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cbt_pkg::seg_t     seg_o
);

  cbt_pkg::point_t pt;
  cbt_pkg::point_t start_d, start_q;
  cbt_pkg::point_t p1_d, p1_q;
  cbt_pkg::point_t p2_d, p2_q;
  logic [1:0]      cnt_d, cnt_q;
  logic            have_d, have_q;
  logic            accept;

  assign pt.x = in_item_i.point_x;
  assign pt.y = in_item_i.point_y;

  assign in_ready_o = !tbl_busy_i && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    start_d = start_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    cnt_d   = cnt_q;
    have_d  = have_q;
    push_o  = 1'b0;
    if (accept) begin
      if (in_item_i.start_new || !have_q) begin
        // drop held points, take this one as the start
        start_d = pt;
        cnt_d   = 2'd0;
        have_d  = 1'b1;
      end else if (cnt_q == 2'd0) begin
        p1_d  = pt;
        cnt_d = 2'd1;
      end else if (cnt_q == 2'd1) begin
        p2_d  = pt;
        cnt_d = 2'd2;
      end else begin
        // segment complete: hand it on, keep the end as next start
        push_o  = 1'b1;
        start_d = pt;
        cnt_d   = 2'd0;
      end
    end
  end

  assign seg_o.p0 = start_q;
  assign seg_o.p1 = p1_q;
  assign seg_o.p2 = p2_q;
  assign seg_o.p3 = pt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      have_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    p1_q    <= p1_d;
    p2_q    <= p2_d;
  end

endmodule

>>> rtl/cbt_seg_queue.sv
// ---------------------------------------------------------------------------
// cbt_seg_queue
// Short FIFO of complete segments between front and back.
// ---------------------------------------------------------------------------
module cbt_seg_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cbt_pkg::seg_t seg_i,
  output logic          full_o,
  output logic          valid_o,
  output cbt_pkg::seg_t seg_o,
  input  logic          pop_i
);

  localparam int Depth = cbt_pkg::SegQueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  cbt_pkg::seg_t   mem_q [Depth];
  logic [PtrW-1:0] wptr_d, wptr_q;
  logic [PtrW-1:0] rptr_d, rptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign seg_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= seg_i;
    end
  end

endmodule

>>> rtl/cbt_wgen.sv
// ---------------------------------------------------------------------------
// cbt_wgen
// Builds the weight table: for j = 0..r stores round(j^3/r^3) and
// round(3 j^2 (r-j)/r^3) in Q1.WeightFracBits, one restoring divide each.
// ---------------------------------------------------------------------------
module cbt_wgen #(
  parameter int MaxResolution  = cbt_pkg::MaxResolution,
  parameter int WeightFracBits = cbt_pkg::WeightFracBits,
  localparam int RW = $clog2(MaxResolution + 1),
  localparam int QW = WeightFracBits + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RW-1:0]   res_i,
  output logic            busy_o,
  output logic            we_o,
  output logic [RW-1:0]   waddr_o,
  output logic [2*QW-1:0] wdata_o
);

  localparam int DW = 3 * RW;
  localparam int CW = $clog2(QW);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul1  = 3'd1;
  localparam logic [2:0] StMul2  = 3'd2;
  localparam logic [2:0] StLoad  = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StWrite = 3'd5;

  logic [2:0]      state_d, state_q;
  logic            req_d, req_q;
  logic [RW-1:0]   j_d, j_q;
  logic [CW-1:0]   cnt_d, cnt_q;
  logic [2*RW-1:0] k2_d, k2_q;
  logic [2*RW-1:0] rr_d, rr_q;
  logic [RW-1:0]   m_d, m_q;
  logic [DW-1:0]   num3_d, num3_q;
  logic [DW-1:0]   num2_d, num2_q;
  logic [DW-1:0]   den_d, den_q;
  logic [DW:0]     rem3_d, rem3_q;
  logic [DW:0]     rem2_d, rem2_q;
  logic [QW-1:0]   low_d, low_q;
  logic [QW-1:0]   q3_d, q3_q;
  logic [QW-1:0]   q2_d, q2_q;
  logic [DW-1:0]   t2;
  logic [DW:0]     dvs;
  logic [DW+1:0]   sh3, sh2;

  assign dvs = {den_q, 1'b0};
  assign sh3 = {rem3_q, low_q[QW-1]};
  assign sh2 = {rem2_q, low_q[QW-1]};
  assign t2  = {{RW{1'b0}}, k2_q} * {{(2*RW){1'b0}}, m_q};

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    k2_d    = k2_q;
    rr_d    = rr_q;
    m_d     = m_q;
    num3_d  = num3_q;
    num2_d  = num2_q;
    den_d   = den_q;
    rem3_d  = rem3_q;
    rem2_d  = rem2_q;
    low_d   = low_q;
    q3_d    = q3_q;
    q2_d    = q2_q;
    we_o    = 1'b0;
    case (state_q)
      StIdle: begin
      end
      StMul1: begin
        k2_d    = {{RW{1'b0}}, j_q} * {{RW{1'b0}}, j_q};
        rr_d    = {{RW{1'b0}}, res_i} * {{RW{1'b0}}, res_i};
        m_d     = res_i - j_q;
        state_d = StMul2;
      end
      StMul2: begin
        num3_d  = {{RW{1'b0}}, k2_q} * {{(2*RW){1'b0}}, j_q};
        num2_d  = t2 + (t2 << 1);
        den_d   = {{RW{1'b0}}, rr_q} * {{(2*RW){1'b0}}, res_i};
        state_d = StLoad;
      end
      StLoad: begin
        // the upper part of the dividend is already below the divisor
        rem3_d  = (DW+1)'(num3_q) + (DW+1)'(den_q >> QW);
        rem2_d  = (DW+1)'(num2_q) + (DW+1)'(den_q >> QW);
        low_d   = QW'(den_q);
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        if (sh3 >= {1'b0, dvs}) begin
          rem3_d = (DW+1)'(sh3 - {1'b0, dvs});
          q3_d   = {q3_q[QW-2:0], 1'b1};
        end else begin
          rem3_d = sh3[DW:0];
          q3_d   = {q3_q[QW-2:0], 1'b0};
        end
        if (sh2 >= {1'b0, dvs}) begin
          rem2_d = (DW+1)'(sh2 - {1'b0, dvs});
          q2_d   = {q2_q[QW-2:0], 1'b1};
        end else begin
          rem2_d = sh2[DW:0];
          q2_d   = {q2_q[QW-2:0], 1'b0};
        end
        low_d = {low_q[QW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        we_o = 1'b1;
        if (j_q == res_i) begin
          state_d = StIdle;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = StMul1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    // restart from the first entry on a pending request
    if (req_q) begin
      state_d = StMul1;
      j_d     = '0;
      req_d   = 1'b0;
    end
    if (start_i) begin
      req_d = 1'b1;
    end
  end

  assign busy_o  = req_q || (state_q != StIdle);
  assign waddr_o = j_q;
  assign wdata_o = {q2_q, q3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      req_q   <= 1'b1;
      j_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k2_q   <= k2_d;
    rr_q   <= rr_d;
    m_q    <= m_d;
    num3_q <= num3_d;
    num2_q <= num2_d;
    den_q  <= den_d;
    rem3_q <= rem3_d;
    rem2_q <= rem2_d;
    low_q  <= low_d;
    q3_q   <= q3_d;
    q2_q   <= q2_d;
  end

endmodule

>>> rtl/cbt_back.sv
// ---------------------------------------------------------------------------
// cbt_back
// Walks k = 0..r for each queued segment: weight lookup, products, sum,
// rounding and saturation, output register. The whole pipe stalls together.
// ---------------------------------------------------------------------------
module cbt_back #(
  parameter int MaxResolution  = cbt_pkg::MaxResolution,
  parameter int WeightFracBits = cbt_pkg::WeightFracBits,
  localparam int RW = $clog2(MaxResolution + 1),
  localparam int QW = WeightFracBits + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RW-1:0]      res_i,
  input  logic               q_valid_i,
  input  cbt_pkg::seg_t      q_seg_i,
  output logic               q_pop_o,
  output logic               ram_re_o,
  output logic [RW-1:0]      ram_raddr_a_o,
  output logic [RW-1:0]      ram_raddr_b_o,
  input  logic [2*QW-1:0]    ram_rdata_a_i,
  input  logic [2*QW-1:0]    ram_rdata_b_i,
  output logic               out_valid_o,
  output cbt_pkg::out_item_t out_item_o,
  input  logic               out_ready_i
);

  localparam int PW  = cbt_pkg::PointW;
  localparam int CW  = cbt_pkg::CoordW;
  localparam int PRW = PW + QW + 1;
  localparam int SW  = PRW + 2;
  localparam int Sh  = WeightFracBits - 8;

  localparam logic signed [SW-1:0] Half     = SW'((1 << Sh) >> 1);
  localparam logic signed [SW-1:0] CoordMax = SW'((2 ** (CW - 1)) - 1);
  localparam logic signed [SW-1:0] CoordMin = SW'(-(2 ** (CW - 1)));

  function automatic logic [CW-1:0] to_q8(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = (s + Half) >>> Sh;
    if (t > CoordMax) begin
      t = CoordMax;
    end else if (t < CoordMin) begin
      t = CoordMin;
    end
    return t[CW-1:0];
  endfunction

  logic                  en;
  logic                  act_d, act_q;
  logic [RW-1:0]         k_d, k_q;
  cbt_pkg::seg_t         seg_d, seg_q;
  logic                  s1_valid_d, s1_valid_q;
  logic                  s1_last_d, s1_last_q;
  cbt_pkg::seg_t         s1_seg_d, s1_seg_q;
  logic                  s2_valid_q, s2_last_q;
  logic                  s3_valid_q, s3_last_q;
  logic                  out_valid_q;
  cbt_pkg::out_item_t    out_item_q;
  cbt_pkg::point_t       pts [4];
  logic [QW-1:0]         w [4];
  logic signed [PRW-1:0] prx_d [4];
  logic signed [PRW-1:0] pry_d [4];
  logic signed [PRW-1:0] prx_q [4];
  logic signed [PRW-1:0] pry_q [4];
  logic signed [SW-1:0]  sumx_d, sumy_d;
  logic signed [SW-1:0]  sumx_q, sumy_q;

  // advance the pipe unless a result waits at the output
  assign en = !out_valid_q || out_ready_i;

  always_comb begin
    act_d      = act_q;
    k_d        = k_q;
    seg_d      = seg_q;
    q_pop_o    = 1'b0;
    s1_valid_d = s1_valid_q;
    s1_last_d  = s1_last_q;
    s1_seg_d   = s1_seg_q;
    if (!act_q) begin
      if (q_valid_i) begin
        q_pop_o = 1'b1;
        seg_d   = q_seg_i;
        k_d     = '0;
        act_d   = 1'b1;
      end
    end
    if (en) begin
      s1_valid_d = act_q;
      s1_last_d  = (k_q == res_i);
      s1_seg_d   = seg_q;
      if (act_q) begin
        if (k_q == res_i) begin
          act_d = 1'b0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
    end
  end

  // table row j holds {w2(j), w3(j)}; w0(k) = w3(r-k), w1(k) = w2(r-k)
  assign ram_re_o      = en;
  assign ram_raddr_a_o = k_q;
  assign ram_raddr_b_o = res_i - k_q;

  assign w[0] = ram_rdata_b_i[QW-1:0];
  assign w[1] = ram_rdata_b_i[2*QW-1:QW];
  assign w[2] = ram_rdata_a_i[2*QW-1:QW];
  assign w[3] = ram_rdata_a_i[QW-1:0];

  assign pts[0] = s1_seg_q.p0;
  assign pts[1] = s1_seg_q.p1;
  assign pts[2] = s1_seg_q.p2;
  assign pts[3] = s1_seg_q.p3;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prx_d[i] = PRW'(pts[i].x) * PRW'($signed({1'b0, w[i]}));
      pry_d[i] = PRW'(pts[i].y) * PRW'($signed({1'b0, w[i]}));
    end
  end

  assign sumx_d = SW'(prx_q[0]) + SW'(prx_q[1]) + SW'(prx_q[2]) + SW'(prx_q[3]);
  assign sumy_d = SW'(pry_q[0]) + SW'(pry_q[1]) + SW'(pry_q[2]) + SW'(pry_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      k_q         <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      act_q      <= act_d;
      k_q        <= k_d;
      s1_valid_q <= s1_valid_d;
      if (en) begin
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q     <= seg_d;
    s1_last_q <= s1_last_d;
    s1_seg_q  <= s1_seg_d;
    if (en) begin
      s2_last_q <= s1_last_q;
      s3_last_q <= s2_last_q;
      for (int i = 0; i < 4; i++) begin
        prx_q[i] <= prx_d[i];
        pry_q[i] <= pry_d[i];
      end
      sumx_q <= sumx_d;
      sumy_q <= sumy_d;
      if (s3_valid_q) begin
        out_item_q.curve_x         <= to_q8(sumx_q);
        out_item_q.curve_y         <= to_q8(sumy_q);
        out_item_q.last_of_segment <= s3_last_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/cubic_bezier_tessellator_core.sv
// ---------------------------------------------------------------------------
// cubic_bezier_tessellator_core: control points in, Bezier curve points out
// The closing control point pushes a segment into the queue; the evaluation pipe
// then gives one point a cycle while the output is not stalled, with a gap between segments.
// After reset and each resolution write the weight table is rebuilt by two
// restoring dividers in parallel; no input is taken meanwhile. Reset async.
// ---------------------------------------------------------------------------
`include "cubic_bezier_tessellator_core_assert.svh"

module cubic_bezier_tessellator_core #(
  parameter int MaxResolution  = cbt_pkg::MaxResolution,
  parameter int WeightFracBits = cbt_pkg::WeightFracBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  cbt_pkg::in_item_t          in_item_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  output cbt_pkg::out_item_t         out_item_o,
  input  logic                       out_ready_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cbt_pkg::PaddrW-1:0] paddr,
  input  logic [cbt_pkg::PdataW-1:0] pwdata,
  output logic [cbt_pkg::PdataW-1:0] prdata,
  output logic                       pready
);

  localparam int RW    = $clog2(MaxResolution + 1);
  localparam int QW    = WeightFracBits + 1;
  localparam int ResW  = cbt_pkg::ResW;
  localparam int DataW = cbt_pkg::PdataW;

  logic [ResW-1:0] res_q;
  logic            cfg_wr;
  logic            res_wr;
  logic [RW-1:0]   r_eff;
  logic            tbl_busy;
  logic            tbl_we;
  logic [RW-1:0]   tbl_waddr;
  logic [2*QW-1:0] tbl_wdata;
  logic            ram_re;
  logic [RW-1:0]   ram_raddr_a;
  logic [RW-1:0]   ram_raddr_b;
  logic [2*QW-1:0] ram_rdata_a;
  logic [2*QW-1:0] ram_rdata_b;
  logic            q_push;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  cbt_pkg::seg_t   front_seg;
  cbt_pkg::seg_t   q_seg;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign res_wr = cfg_wr && (paddr == cbt_pkg::RegResolution);
  assign prdata = (paddr == cbt_pkg::RegResolution) ?
                  {{(DataW - ResW){1'b0}}, res_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= cbt_pkg::ResolutionReset;
    end else if (res_wr) begin
      res_q <= pwdata[ResW-1:0];
    end
  end

  // clamp zero up to one and large values down to MaxResolution
  always_comb begin
    if (res_q == '0) begin
      r_eff = RW'(1);
    end else if (res_q > ResW'(MaxResolution)) begin
      r_eff = RW'(MaxResolution);
    end else begin
      r_eff = RW'(res_q);
    end
  end

  cbt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .tbl_busy_i (tbl_busy),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .seg_o      (front_seg)
  );

  cbt_seg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .seg_i   (front_seg),
    .full_o  (q_full),
    .valid_o (q_valid),
    .seg_o   (q_seg),
    .pop_i   (q_pop)
  );

  cbt_wgen #(
    .MaxResolution  (MaxResolution),
    .WeightFracBits (WeightFracBits)
  ) u_wgen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (res_wr),
    .res_i   (r_eff),
    .busy_o  (tbl_busy),
    .we_o    (tbl_we),
    .waddr_o (tbl_waddr),
    .wdata_o (tbl_wdata)
  );

  cbt_ram #(
    .Width (2 * QW),
    .Depth (MaxResolution + 1)
  ) u_weight_ram (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (tbl_waddr),
    .wdata_i   (tbl_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  cbt_back #(
    .MaxResolution  (MaxResolution),
    .WeightFracBits (WeightFracBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (r_eff),
    .q_valid_i     (q_valid),
    .q_seg_i       (q_seg),
    .q_pop_o       (q_pop),
    .ram_re_o      (ram_re),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .ram_rdata_a_i (ram_rdata_a),
    .ram_rdata_b_i (ram_rdata_b),
    .out_valid_o   (out_valid_o),
    .out_item_o    (out_item_o),
    .out_ready_i   (out_ready_i)
  );

  `CBT_ASSERT_SAME(a_no_input_during_build, tbl_busy, !in_ready_o)
  `CBT_ASSERT_SAME(a_no_push_when_full, q_push, !q_full)
  `CBT_ASSERT_SAME(a_push_only_on_accept, q_push, in_valid_i && in_ready_o)
  `CBT_ASSERT_NEXT(a_write_starts_build, res_wr, tbl_busy && !in_ready_o)

endmodule
